// ===== hw/rtl/tracked_id_table_with_aging_assert.svh =====
// Assertion macros for the tracked address table.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef TRACKED_ID_TABLE_WITH_AGING_ASSERT_SVH
`define TRACKED_ID_TABLE_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS
`define TITA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracked table check failed");
`define TITA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracked table check failed");
`else
`define TITA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TITA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/tita_pkg.sv =====
// Shared widths, action codes and entry type for the tracked address table.
// No dependencies.
package tita_pkg;

   localparam int unsigned MAX_ENTRIES_DEF = 128;
   localparam int unsigned ACT_W           = 3;
   localparam int unsigned KEY_W           = 24;
   localparam int unsigned TIME_W          = 32;
   localparam int unsigned SLOT_W          = 7;
   localparam int unsigned COUNT_W         = 8;
   localparam int unsigned DATA_W          = 32;
   localparam int unsigned ADDR_W          = 3;

   localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60000;

   localparam logic [ACT_W-1:0] ACT_TOUCH  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_PRUNE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic REG_INTERVAL = 1'b0;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] seen;
   } entry_type;

endpackage

// ===== hw/rtl/tita_csr.sv =====
// Configuration register block: holds the prune interval behind an APB-style port.
// Depends on tita_pkg.
module tita_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tita_pkg::ADDR_W-1:0]   paddr,
   input  logic [tita_pkg::DATA_W-1:0]   pwdata,
   output logic [tita_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [tita_pkg::TIME_W-1:0]   interval
);
   import tita_pkg::*;

   logic [TIME_W-1:0] interval_ff;
   logic [TIME_W-1:0] interval_in;
   logic              hit_reg;

   assign hit_reg = (paddr[ADDR_W-1] == REG_INTERVAL) && (paddr[ADDR_W-2:0] == '0);

   always_comb begin
      interval_in = interval_ff;
      if (psel && penable && pwrite && hit_reg) begin
         interval_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   assign prdata   = hit_reg ? interval_ff : '0;
   assign pready   = 1'b1;
   assign interval = interval_ff;

endmodule

// ===== hw/rtl/tita_store.sv =====
// Entry memory: key and last-seen time per slot, one write and one registered read port.
// Depends on tita_pkg.
module tita_store #(
   parameter int unsigned DEPTH = tita_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned IW    = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_idx,
   input  tita_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_idx,
   output tita_pkg::entry_type rd_data
);
   import tita_pkg::*;

   entry_type entry_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tracked_id_table_with_aging.sv =====
// Tracked address table with aging: top level, scan sequencer and valid bits.
// Depends on tita_pkg, tita_csr, tita_store and tracked_id_table_with_aging_assert.svh.
//
// Touch, remove, query and prune keep busy high while the sequencer scans every
// entry and then updates; a new item is taken only when busy is low. The
// sequencer reads one entry a cycle through the single read port of the entry
// memory, checks it in the following cycle, and updates in the done state. Clear
// and unknown actions are handled from idle without raising busy. rsp_strobe marks
// each result for exactly one cycle and the receiver cannot stall it; the next item
// may be started while that result is shown. No clearing pass follows reset.
`include "tracked_id_table_with_aging_assert.svh"

module tracked_id_table_with_aging #(
   parameter int unsigned MAX_ENTRIES = tita_pkg::MAX_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tita_pkg::ACT_W-1:0]    req_action,
   input  logic [tita_pkg::KEY_W-1:0]    req_icao_address,
   input  logic [tita_pkg::TIME_W-1:0]   req_timestamp_ms,
   output logic                          rsp_strobe,
   output logic                          rsp_ok,
   output logic [tita_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_created,
   output logic [tita_pkg::COUNT_W-1:0]  rsp_entry_count,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tita_pkg::ADDR_W-1:0]   paddr,
   input  logic [tita_pkg::DATA_W-1:0]   pwdata,
   output logic [tita_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import tita_pkg::*;

   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [ACT_W-1:0]    act_ff, act_in;
   logic [KEY_W-1:0]    addr_ff, addr_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                iss_on_ff, iss_on_in;
   logic [IW-1:0]       iss_idx_ff, iss_idx_in;
   logic                chk_on_ff, chk_on_in;
   logic [IW-1:0]       chk_idx_ff, chk_idx_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                chk_last_ff, chk_last_in;
   logic                hit_ff, hit_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_created_ff, rsp_created_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [TIME_W-1:0]   interval;
   logic [TIME_W-1:0]   age;
   logic                wr_en;
   logic [IW-1:0]       wr_idx;
   entry_type           wr_data;
   entry_type           rd_data;
   logic                slot_use;
   logic [IW-1:0]       slot_sel;
   logic [IW+SLOT_W-1:0]  slot_wide;
   logic [CW+COUNT_W-1:0] count_wide;

   tita_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .interval (interval)
   );

   tita_store #(
      .DEPTH (MAX_ENTRIES),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (iss_on_ff),
      .rd_idx  (iss_idx_ff),
      .rd_data (rd_data)
   );

   assign age     = now_ff - rd_data.seen;
   assign wr_data = '{key: addr_ff, seen: now_ff};

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      addr_in        = addr_ff;
      now_in         = now_ff;
      iss_on_in      = iss_on_ff;
      iss_idx_in     = iss_idx_ff;
      chk_on_in      = 1'b0;
      chk_idx_in     = iss_idx_ff;
      chk_vld_in     = valid_ff[iss_idx_ff];
      chk_last_in    = (iss_idx_ff == LAST_IDX);
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      valid_in       = valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_ok_in      = 1'b0;
      rsp_created_in = 1'b0;
      slot_use       = 1'b0;
      slot_sel       = hit_idx_ff;
      wr_en          = 1'b0;
      wr_idx         = hit_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in  = req_action;
               addr_in = req_icao_address;
               now_in  = req_timestamp_ms;
               if (req_action == ACT_TOUCH || req_action == ACT_REMOVE ||
                   req_action == ACT_QUERY || req_action == ACT_PRUNE) begin
                  state_in   = ST_SCAN;
                  iss_on_in  = 1'b1;
                  iss_idx_in = '0;
                  hit_in     = 1'b0;
                  free_in    = 1'b0;
               end else if (req_action == ACT_CLEAR) begin
                  valid_in      = '0;
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b1;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (iss_on_ff) begin
               chk_on_in  = 1'b1;
               iss_idx_in = iss_idx_ff + IW'(1);
               if (iss_idx_ff == LAST_IDX) begin
                  iss_on_in = 1'b0;
               end
            end
            if (chk_on_ff) begin
               if (chk_vld_ff && rd_data.key == addr_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
               end
               if (!chk_vld_ff && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (act_ff == ACT_PRUNE && chk_vld_ff && age > interval) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  count_in             = count_ff - CW'(1);
               end
               if (chk_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            priority if (act_ff == ACT_TOUCH) begin
               if (hit_ff) begin
                  wr_en     = 1'b1;
                  rsp_ok_in = 1'b1;
                  slot_use  = 1'b1;
               end else if (free_ff) begin
                  wr_en                 = 1'b1;
                  wr_idx                = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CW'(1);
                  rsp_ok_in             = 1'b1;
                  rsp_created_in        = 1'b1;
                  slot_use              = 1'b1;
                  slot_sel              = free_idx_ff;
               end
            end else if (act_ff == ACT_REMOVE) begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in             = count_ff - CW'(1);
                  rsp_ok_in            = 1'b1;
                  slot_use             = 1'b1;
               end
            end else if (act_ff == ACT_QUERY) begin
               if (hit_ff) begin
                  rsp_ok_in = 1'b1;
                  slot_use  = 1'b1;
               end
            end else begin
               rsp_ok_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      slot_wide    = {{SLOT_W{1'b0}}, slot_sel};
      rsp_slot_in  = slot_use ? slot_wide[SLOT_W-1:0] : '0;
      count_wide   = {{COUNT_W{1'b0}}, count_in};
      rsp_count_in = count_wide[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_on_ff     <= 1'b0;
         chk_on_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         count_ff      <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_on_ff     <= iss_on_in;
         chk_on_ff     <= chk_on_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      addr_ff        <= addr_in;
      now_ff         <= now_in;
      iss_idx_ff     <= iss_idx_in;
      chk_idx_ff     <= chk_idx_in;
      chk_vld_ff     <= chk_vld_in;
      chk_last_ff    <= chk_last_in;
      hit_idx_ff     <= hit_idx_in;
      free_idx_ff    <= free_idx_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_created_ff <= rsp_created_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_created     = rsp_created_ff;
   assign rsp_entry_count = rsp_count_ff;

   `TITA_ASSERT_IMPLIES(a_count_matches_valid, clock, reset, 1'b1, count_ff == CW'($countones(valid_ff)))
   `TITA_ASSERT_NEXT(a_done_gives_result, clock, reset, state_ff == ST_DONE, rsp_strobe && !busy)
   `TITA_ASSERT_IMPLIES(a_created_is_ok, clock, reset, rsp_strobe && rsp_created, rsp_ok)
   `TITA_ASSERT_IMPLIES(a_no_scan_when_idle, clock, reset, state_ff == ST_IDLE, !iss_on_ff && !chk_on_ff)

endmodule
